// ----- rtl/jtt_pkg.sv -----
// ----------------------------------------------------------------------------
// jtt_pkg
// shared types and constants of the job timer table
// ----------------------------------------------------------------------------
package jtt_pkg;

    // request codes
    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_ENABLE = 2'd2,
        REQ_SCAN   = 2'd3
    } t_req;

    // job kinds
    localparam logic [1:0] KIND_ONESHOT  = 2'd0;
    localparam logic [1:0] KIND_INTERVAL = 2'd1;
    localparam logic [1:0] KIND_DAILY    = 2'd2;
    localparam logic [1:0] KIND_WEEKLY   = 2'd3;

    // reply kinds and status codes
    localparam logic       REPLY_ACK   = 1'b0;
    localparam logic       REPLY_FIRE  = 1'b1;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // arithmetic constants
    localparam int          TICK_DIVISOR  = 1000;
    localparam logic [15:0] DEFAULT_RATE  = 16'd250;
    localparam int          HOURS_PER_DAY = 24;
    localparam int          MINS_PER_HOUR = 60;
    localparam logic [31:0] KEY_NONE      = 32'hFFFF_FFFF;

    // product width of ms times rate
    localparam int PROD_W = 48;

    // divide by 1000 as a shift by 3 and a divide by 125; the divide by 125
    // is a multiply by ceil(2^52 / 125), exact for dividends below 2^45,
    // done in three 16-bit slices of the reciprocal
    localparam int          DIV_SHIFT    = 3;
    localparam int          DIV_ODD      = TICK_DIVISOR >> DIV_SHIFT;
    localparam int          RECIP_SH     = 52;
    localparam int          RECIP_SLICES = 3;
    localparam logic [47:0] RECIP        =
        48'(((64'd1 << RECIP_SH) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD));

    // decoded request as it sits in the queue
    typedef struct packed {
        t_req        req;
        logic [1:0]  kind;
        logic [1:0]  action;
        logic [31:0] ms;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [2:0]  wday;
        logic [15:0] key;
        logic [31:0] id;
        logic        en;
        logic [63:0] now;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic        reply_kind;
        logic [1:0]  status;
        logic [31:0] id;
        logic [3:0]  slot;
        logic [1:0]  action;
        logic [31:0] runs;
        logic        last;
    } t_result;

    // sequencer states of the back part
    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE,
        S_RD,
        S_EV,
        S_FIRE,
        S_DIV,
        S_UPD,
        S_UPD2,
        S_REPLY
    } t_state;

    // tick conversion unit states
    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_RUN,
        D_DONE
    } t_div_state;

endpackage

// ----- rtl/jtt_tickdiv.sv -----
// ----------------------------------------------------------------------------
// jtt_tickdiv
// converts milliseconds to ticks: ms * rate / 1000, at least one
// ----------------------------------------------------------------------------
module jtt_tickdiv import jtt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_ms,
    input  logic [15:0]         i_hz,
    output logic                o_done,
    output logic [PROD_W-1:0]   o_step
);

    localparam int XW = PROD_W - DIV_SHIFT;
    localparam int PW = XW + 16;
    localparam int AW = XW + 48;
    localparam int QW = AW - RECIP_SH;

    t_div_state        r_state;
    logic [31:0]       r_ms;
    logic [15:0]       r_hz;
    logic [XW-1:0]     r_x;
    logic [AW-1:0]     r_acc;
    logic [1:0]        r_cnt;
    logic [15:0]       slice;
    logic [PW-1:0]     part;
    logic [AW-1:0]     n_acc;
    logic [QW-1:0]     quo;

    // reciprocal slice for this cycle, most significant first
    always_comb begin
        case (r_cnt)
            2'd0:    slice = RECIP[47:32];
            2'd1:    slice = RECIP[31:16];
            default: slice = RECIP[15:0];
        endcase
    end

    // one partial product per cycle, accumulated high slice first
    assign part  = PW'(r_x) * PW'(slice);
    assign n_acc = {r_acc[AW-17:0], 16'd0} + AW'(part);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                D_IDLE: if (i_start) r_state <= D_MUL;
                D_MUL: begin
                    r_state <= D_RUN;
                    r_cnt   <= '0;
                end
                D_RUN: begin
                    if (r_cnt == 2'(RECIP_SLICES - 1)) r_state <= D_DONE;
                    r_cnt <= r_cnt + 1'b1;
                end
                D_DONE: r_state <= D_IDLE;
                default: r_state <= D_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_ms <= i_ms;
            r_hz <= i_hz;
        end
        if (r_state == D_MUL) begin
            r_x   <= XW'((PROD_W'(r_ms) * PROD_W'(r_hz)) >> DIV_SHIFT);
            r_acc <= '0;
        end else if (r_state == D_RUN) begin
            r_acc <= n_acc;
        end
    end

    assign quo    = r_acc[AW-1:RECIP_SH];
    assign o_done = (r_state == D_DONE);
    assign o_step = (quo == '0) ? PROD_W'(1) : PROD_W'(quo);

endmodule

// ----- rtl/jtt_front.sv -----
// ----------------------------------------------------------------------------
// jtt_front
// accepts request items, decodes them and queues them for the sequencer
// ----------------------------------------------------------------------------
module jtt_front import jtt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_job_kind,
    input  logic [1:0]  i_action_code,
    input  logic [31:0] i_interval_ms,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [2:0]  i_weekday,
    input  logic [4:0]  i_clock_day,
    input  logic [31:0] i_job_id,
    input  logic        i_enable_flag,
    input  logic [63:0] i_now_tick,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);

    t_cmd        r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        accept;
    t_cmd        cmd;
    logic [9:0]  day_hour;

    assign o_in_stall = (r_cnt == 2'd2);
    assign accept     = i_in_valid && !o_in_stall;

    // dedup key: minutes since start of month
    assign day_hour = 10'(i_clock_day) * 10'(HOURS_PER_DAY) + 10'(i_hour);

    always_comb begin
        cmd.req    = t_req'(i_req_type);
        cmd.kind   = i_job_kind;
        cmd.action = i_action_code;
        cmd.ms     = i_interval_ms;
        cmd.hour   = i_hour;
        cmd.minute = i_minute;
        cmd.wday   = i_weekday;
        cmd.key    = 16'(day_hour) * 16'(MINS_PER_HOUR) + 16'(i_minute);
        cmd.id     = i_job_id;
        cmd.en     = i_enable_flag;
        cmd.now    = i_now_tick;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (accept) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(accept) - 2'(i_cmd_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (accept) r_q[r_wp] <= cmd;
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

endmodule

// ----- rtl/jtt_engine.sv -----
// ----------------------------------------------------------------------------
// jtt_engine
// slot table and sequencer: walks the slots, updates jobs, emits results
// ----------------------------------------------------------------------------
module jtt_engine import jtt_pkg::*; #(
    parameter int MAX_JOBS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    input  logic [15:0] i_hz,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out
);

    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    // slot memories
    logic [1:0]  m_kind   [MAX_JOBS];
    logic [1:0]  m_action [MAX_JOBS];
    logic [31:0] m_id     [MAX_JOBS];
    logic [31:0] m_ival   [MAX_JOBS];
    logic [63:0] m_next   [MAX_JOBS];
    logic [13:0] m_time   [MAX_JOBS];
    logic [31:0] m_key    [MAX_JOBS];
    logic [31:0] m_runs   [MAX_JOBS];

    logic [1:0]  rd_kind;
    logic [1:0]  rd_action;
    logic [31:0] rd_id;
    logic [31:0] rd_ival;
    logic [63:0] rd_next;
    logic [13:0] rd_time;
    logic [31:0] rd_key;
    logic [31:0] rd_runs;

    t_state                r_state, n_state;
    logic [IW-1:0]         r_idx, n_idx;
    t_cmd                  r_cmd;
    logic [MAX_JOBS-1:0]   r_used, n_used;
    logic [MAX_JOBS-1:0]   r_en, n_en;
    logic [31:0]           r_next_id, n_next_id;
    t_result               r_rep, n_rep;
    logic [PROD_W-1:0]     r_step, n_step;
    logic [63:0]           r_sum_a, n_sum_a, r_sum_b, n_sum_b;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  out_free;
    logic                  push;
    t_result               push_data;
    logic                  last_slot;
    logic                  id_hit;
    logic                  scan_fire;
    logic                  div_start;
    logic [31:0]           div_ms;
    logic                  div_done;
    logic [PROD_W-1:0]     div_step;
    logic                  w_add;
    logic                  w_next_en;
    logic [63:0]           w_next_data;
    logic                  w_runs_en;
    logic [31:0]           w_runs_data;
    logic                  w_key_en;
    logic [31:0]           w_key_data;
    t_result               ack_scan;

    jtt_tickdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_ms    (div_ms),
        .i_hz    (i_hz),
        .o_done  (div_done),
        .o_step  (div_step)
    );

    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_slot = (r_idx == IW'(MAX_JOBS - 1));
    assign id_hit    = r_used[r_idx] && (rd_id == r_cmd.id);
    assign ack_scan  = '{REPLY_ACK, ST_OK, 32'd0, 4'd0, 2'd0, 32'd0, 1'b1};

    // due check for the slot under the read port
    always_comb begin
        scan_fire = 1'b0;
        if (r_used[r_idx] && r_en[r_idx]) begin
            if (!rd_kind[1]) begin
                scan_fire = (r_cmd.now >= rd_next);
            end else begin
                scan_fire = (rd_time[13:9] == r_cmd.hour) &&
                            (rd_time[8:3] == r_cmd.minute) &&
                            (32'(r_cmd.key) != rd_key) &&
                            (rd_kind == KIND_DAILY || rd_time[2:0] == r_cmd.wday);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) n_state = (i_cmd.req == REQ_ADD) ? S_FREE : S_RD;
            end
            S_FREE: begin
                if (!r_used[r_idx]) begin
                    n_state = r_cmd.kind[1] ? S_UPD : S_DIV;
                end else if (last_slot) begin
                    n_state = S_REPLY;
                end
            end
            S_RD: n_state = S_EV;
            S_EV: begin
                if (r_cmd.req == REQ_SCAN) begin
                    if (scan_fire) n_state = S_FIRE;
                    else n_state = last_slot ? S_REPLY : S_RD;
                end else if (id_hit) begin
                    if (r_cmd.req == REQ_ENABLE && r_cmd.en && !rd_kind[1]) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_REPLY;
                    end
                end else begin
                    n_state = last_slot ? S_REPLY : S_RD;
                end
            end
            S_FIRE: begin
                if (out_free) begin
                    if (rd_kind == KIND_INTERVAL) n_state = S_DIV;
                    else n_state = last_slot ? S_REPLY : S_RD;
                end
            end
            S_DIV: if (div_done) n_state = S_UPD;
            S_UPD: n_state = (r_cmd.req == REQ_SCAN) ? S_UPD2 : S_REPLY;
            S_UPD2: n_state = last_slot ? S_REPLY : S_RD;
            S_REPLY: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs and slot updates
    always_comb begin
        n_idx       = r_idx;
        n_used      = r_used;
        n_en        = r_en;
        n_next_id   = r_next_id;
        n_rep       = r_rep;
        n_step      = r_step;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        o_cmd_pop   = 1'b0;
        div_start   = 1'b0;
        div_ms      = rd_ival;
        w_add       = 1'b0;
        w_next_en   = 1'b0;
        w_next_data = 64'd0;
        w_runs_en   = 1'b0;
        w_runs_data = rd_runs + 32'd1;
        w_key_en    = 1'b0;
        w_key_data  = 32'(r_cmd.key);
        push        = 1'b0;
        push_data   = r_rep;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_idx     = '0;
                end
            end
            S_FREE: begin
                if (!r_used[r_idx]) begin
                    if (!r_cmd.kind[1]) begin
                        div_start = 1'b1;
                        div_ms    = r_cmd.ms;
                    end
                end else if (last_slot) begin
                    n_rep = '{REPLY_ACK, ST_FULL, 32'd0, 4'd0, 2'd0, 32'd0, 1'b1};
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EV: begin
                if (r_cmd.req == REQ_SCAN) begin
                    if (!scan_fire) begin
                        if (last_slot) n_rep = ack_scan;
                        else n_idx = r_idx + 1'b1;
                    end
                end else if (id_hit) begin
                    n_rep = '{REPLY_ACK, ST_OK, r_cmd.id, 4'(r_idx), 2'd0, 32'd0, 1'b1};
                    if (r_cmd.req == REQ_REMOVE) begin
                        n_used[r_idx] = 1'b0;
                        n_en[r_idx]   = 1'b0;
                    end else begin
                        n_en[r_idx] = r_cmd.en;
                        if (r_cmd.en && !rd_kind[1]) div_start = 1'b1;
                    end
                end else if (last_slot) begin
                    n_rep = '{REPLY_ACK, ST_NOTFOUND, r_cmd.id, 4'd0, 2'd0, 32'd0, 1'b1};
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FIRE: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_data = '{REPLY_FIRE, ST_OK, rd_id, 4'(r_idx), rd_action,
                                  rd_runs + 32'd1, 1'b0};
                    w_runs_en = 1'b1;
                    if (rd_kind[1]) w_key_en = 1'b1;
                    if (rd_kind == KIND_ONESHOT) begin
                        n_en[r_idx] = 1'b0;
                        w_next_en   = 1'b1;
                    end
                    if (rd_kind == KIND_INTERVAL) begin
                        div_start = 1'b1;
                    end else if (last_slot) begin
                        n_rep = ack_scan;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (div_done) n_step = div_step;
            end
            S_UPD: begin
                case (r_cmd.req)
                    REQ_ADD: begin
                        w_add         = 1'b1;
                        w_runs_en     = 1'b1;
                        w_runs_data   = 32'd0;
                        w_key_en      = 1'b1;
                        w_key_data    = KEY_NONE;
                        w_next_en     = 1'b1;
                        w_next_data   = r_cmd.kind[1] ? 64'd0 : r_cmd.now + 64'(r_step);
                        n_used[r_idx] = 1'b1;
                        n_en[r_idx]   = r_cmd.en;
                        n_next_id     = r_next_id + 32'd1;
                        n_rep = '{REPLY_ACK, ST_OK, r_next_id, 4'(r_idx), 2'd0, 32'd0, 1'b1};
                    end
                    REQ_ENABLE: begin
                        w_next_en   = 1'b1;
                        w_next_data = r_cmd.now + 64'(r_step);
                    end
                    default: begin
                        n_sum_a = rd_next + 64'(r_step);
                        n_sum_b = r_cmd.now + 64'(r_step);
                    end
                endcase
            end
            S_UPD2: begin
                // catch up to now plus one step when behind
                w_next_en   = 1'b1;
                w_next_data = (r_sum_a <= r_cmd.now) ? r_sum_b : r_sum_a;
                if (last_slot) n_rep = ack_scan;
                else n_idx = r_idx + 1'b1;
            end
            S_REPLY: begin
                if (out_free) push = 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_used      <= '0;
            r_en        <= '0;
            r_next_id   <= 32'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_used    <= n_used;
            r_en      <= n_en;
            r_next_id <= n_next_id;
            if (push) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_cmd <= i_cmd;
        if (push) r_out <= push_data;
        r_rep   <= n_rep;
        r_step  <= n_step;
        r_sum_a <= n_sum_a;
        r_sum_b <= n_sum_b;
    end

    // slot memory writes
    always_ff @(posedge i_clk) begin
        if (w_add) begin
            m_kind[r_idx]   <= r_cmd.kind;
            m_action[r_idx] <= r_cmd.action;
            m_id[r_idx]     <= r_next_id;
            m_ival[r_idx]   <= r_cmd.ms;
            m_time[r_idx]   <= {r_cmd.hour, r_cmd.minute, r_cmd.wday};
        end
        if (w_next_en) m_next[r_idx] <= w_next_data;
        if (w_runs_en) m_runs[r_idx] <= w_runs_data;
        if (w_key_en) m_key[r_idx] <= w_key_data;
    end

    // slot memory reads
    always_ff @(posedge i_clk) begin
        rd_kind   <= m_kind[r_idx];
        rd_action <= m_action[r_idx];
        rd_id     <= m_id[r_idx];
        rd_ival   <= m_ival[r_idx];
        rd_next   <= m_next[r_idx];
        rd_time   <= m_time[r_idx];
        rd_key    <= m_key[r_idx];
        rd_runs   <= m_runs[r_idx];
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // fire results are never the closing item
    a_fire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.reply_kind == REPLY_FIRE) |-> !r_out.last)
        else $error("fire result marked last");

    // fire results only while a scan is in progress
    a_fire_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.reply_kind == REPLY_FIRE) |-> (r_cmd.req == REQ_SCAN))
        else $error("fire result outside a scan");

    // the slot walk stays inside the table
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IW'(MAX_JOBS - 1))
        else $error("slot index out of range");

    // ids are consumed only by a successful add
    a_id_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_next_id != $past(r_next_id)) |->
        ($past(r_state) == S_UPD && $past(r_cmd.req) == REQ_ADD))
        else $error("job id advanced outside an add");

endmodule

// ----- rtl/job_timer_table.sv -----
// ----------------------------------------------------------------------------
// job_timer_table
// table of job timers with tick and wall-clock alarms
// ----------------------------------------------------------------------------
// Requests enter on the input channel (i_in_valid / o_in_stall) and go into a
// two-entry queue, so two items can be taken while the sequencer is busy.
// Each request yields one acknowledge; a scan yields one fire item per due job
// and then the acknowledge, with o_last_item set on the final item only.
// Results leave through one output register (o_out_valid / i_out_stall); when
// the receiver stalls, the item holds and the sequencer waits on it.
// The sequencer walks slots through the slot memories' registered read port,
// reading and then evaluating each slot visited. Converting ms to ticks (an
// add of a tick job, enabling a tick job, each interval job fired) is a
// multiply by the rate and then a reciprocal multiply for the divide by 1000
// in three slices. The tick rate register is written through i_cfg_valid /
// o_cfg_ready, always ready; the user must write it only while the block is
// idle, which the block itself does not enforce. Reset empties the table,
// sets the next id to 1 and the tick rate to 250; no clearing pass is needed.
// ----------------------------------------------------------------------------
module job_timer_table import jtt_pkg::*; #(
    parameter int MAX_JOBS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_job_kind,
    input  logic [1:0]  i_action_code,
    input  logic [31:0] i_interval_ms,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [2:0]  i_weekday,
    input  logic [4:0]  i_clock_day,
    input  logic [31:0] i_job_id,
    input  logic        i_enable_flag,
    input  logic [63:0] i_now_tick,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_reply_kind,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_id,
    output logic [3:0]  o_result_slot,
    output logic [1:0]  o_result_action,
    output logic [31:0] o_result_runs,
    output logic        o_last_item
);

    logic [15:0] r_tick_rate;
    logic [15:0] hz;
    logic        cmd_valid;
    t_cmd        cmd;
    logic        cmd_pop;
    t_result     res;

    // tick rate register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= DEFAULT_RATE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tick_rate <= i_cfg_data;
        end
    end

    // a rate of zero counts as the default
    assign hz = (r_tick_rate == 16'd0) ? DEFAULT_RATE : r_tick_rate;

    jtt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_job_kind    (i_job_kind),
        .i_action_code (i_action_code),
        .i_interval_ms (i_interval_ms),
        .i_hour        (i_hour),
        .i_minute      (i_minute),
        .i_weekday     (i_weekday),
        .i_clock_day   (i_clock_day),
        .i_job_id      (i_job_id),
        .i_enable_flag (i_enable_flag),
        .i_now_tick    (i_now_tick),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    jtt_engine #(.MAX_JOBS(MAX_JOBS)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_hz        (hz),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (res)
    );

    assign o_reply_kind    = res.reply_kind;
    assign o_status        = res.status;
    assign o_result_id     = res.id;
    assign o_result_slot   = res.slot;
    assign o_result_action = res.action;
    assign o_result_runs   = res.runs;
    assign o_last_item     = res.last;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the job timer table
// ----------------------------------------------------------------------------
// A walked table of directed requests (empty scan, adds of every kind,
// unknown ids, re-arming, wall-clock matches and dedup, tick wrap) runs first.
// Four random phases follow, each under its own tick rate (0, 65535, 1, any).
// Every accepted request goes through a local model of the table, which
// queues the replies it should produce. Each reply that leaves the block is
// checked against the oldest queued one. Both sides idle at random, except
// in one quiet stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import jtt_pkg::*;

    localparam int NJOBS     = 16;
    localparam int CYC_LIMIT = 1000000;

    // one request item as the bench sees it
    typedef struct {
        t_req        req;
        logic [1:0]  kind;
        logic [1:0]  action;
        logic [31:0] ms;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [2:0]  wday;
        logic [4:0]  day;
        logic [31:0] id;
        logic        en;
        logic [63:0] now;
        bit          typed;
        t_result     want;
    } t_request;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_req_type;
    logic [1:0]  i_job_kind;
    logic [1:0]  i_action_code;
    logic [31:0] i_interval_ms;
    logic [4:0]  i_hour;
    logic [5:0]  i_minute;
    logic [2:0]  i_weekday;
    logic [4:0]  i_clock_day;
    logic [31:0] i_job_id;
    logic        i_enable_flag;
    logic [63:0] i_now_tick;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_reply_kind;
    logic [1:0]  o_status;
    logic [31:0] o_result_id;
    logic [3:0]  o_result_slot;
    logic [1:0]  o_result_action;
    logic [31:0] o_result_runs;
    logic        o_last_item;

    job_timer_table #(.MAX_JOBS(NJOBS)) i_dut (.*);

    // model copy of the table
    logic [15:0] rate_hz;
    logic        job_used    [NJOBS];
    logic        job_enabled [NJOBS];
    logic [1:0]  job_kind    [NJOBS];
    logic [1:0]  job_action  [NJOBS];
    logic [31:0] job_id      [NJOBS];
    logic [31:0] job_ms      [NJOBS];
    logic [63:0] job_due     [NJOBS];
    logic [4:0]  job_hour    [NJOBS];
    logic [5:0]  job_minute  [NJOBS];
    logic [2:0]  job_wday    [NJOBS];
    logic [31:0] job_key     [NJOBS];
    logic [31:0] job_runs    [NJOBS];
    logic [31:0] id_counter;

    t_result     replies_due[$];
    int          n_err;
    int          cycles;
    bit          quiet;
    logic [63:0] cur_now;

    // clock and reset
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic bit idle_now();
        return !quiet && ($urandom_range(0, 99) < 38);
    endfunction

    // ms to ticks at the current rate, never below one
    function automatic logic [63:0] ms_to_ticks(logic [31:0] ms);
        logic [63:0] hz;
        logic [63:0] t;
        hz = (rate_hz != 0) ? {48'd0, rate_hz} : {48'd0, DEFAULT_RATE};
        t  = {32'd0, ms} * hz / TICK_DIVISOR;
        return (t != 0) ? t : 64'd1;
    endfunction

    function automatic t_result ack(logic [1:0] st, logic [31:0] id, logic [3:0] slot);
        t_result r;
        r = '{REPLY_ACK, st, id, slot, 2'd0, 32'd0, 1'b1};
        return r;
    endfunction

    function automatic int find_job(logic [31:0] id);
        for (int i = 0; i < NJOBS; i++)
            if (job_used[i] && job_id[i] == id) return i;
        return -1;
    endfunction

    // model one request and queue the replies it produces
    function automatic void serve_request(t_request q);
        int          s;
        bit          fire;
        logic [31:0] key;
        logic [63:0] step;
        s = -1;
        case (q.req)
            REQ_ADD: begin
                for (int i = NJOBS - 1; i >= 0; i--)
                    if (!job_used[i]) s = i;
                if (s < 0) begin
                    replies_due.push_back(ack(ST_FULL, 32'd0, 4'd0));
                end else begin
                    job_used[s]    = 1'b1;
                    job_enabled[s] = q.en;
                    job_kind[s]    = q.kind;
                    job_action[s]  = q.action;
                    job_id[s]      = id_counter;
                    id_counter     = id_counter + 1;
                    job_ms[s]      = q.ms;
                    job_hour[s]    = q.hour;
                    job_minute[s]  = q.minute;
                    job_wday[s]    = q.wday;
                    job_key[s]     = KEY_NONE;
                    job_runs[s]    = 32'd0;
                    job_due[s]     = (q.kind == KIND_ONESHOT || q.kind == KIND_INTERVAL) ?
                                     q.now + ms_to_ticks(q.ms) : 64'd0;
                    replies_due.push_back(ack(ST_OK, job_id[s], s[3:0]));
                end
            end
            REQ_REMOVE, REQ_ENABLE: begin
                s = find_job(q.id);
                if (s < 0) begin
                    replies_due.push_back(ack(ST_NOTFOUND, q.id, 4'd0));
                end else begin
                    if (q.req == REQ_REMOVE) begin
                        job_used[s]    = 1'b0;
                        job_enabled[s] = 1'b0;
                    end else begin
                        job_enabled[s] = q.en;
                        if (q.en && (job_kind[s] == KIND_ONESHOT || job_kind[s] == KIND_INTERVAL))
                            job_due[s] = q.now + ms_to_ticks(job_ms[s]);
                    end
                    replies_due.push_back(ack(ST_OK, q.id, s[3:0]));
                end
            end
            default: begin
                key = ({27'd0, q.day} * HOURS_PER_DAY + q.hour) * MINS_PER_HOUR + q.minute;
                for (int i = 0; i < NJOBS; i++) begin
                    fire = 0;
                    if (job_used[i] && job_enabled[i]) begin
                        if (job_kind[i] == KIND_ONESHOT || job_kind[i] == KIND_INTERVAL) begin
                            fire = (q.now >= job_due[i]);
                        end else if (q.hour == job_hour[i] && q.minute == job_minute[i] &&
                                     key != job_key[i] &&
                                     (job_kind[i] == KIND_DAILY || q.wday == job_wday[i])) begin
                            job_key[i] = key;
                            fire = 1;
                        end
                    end
                    if (fire) begin
                        job_runs[i] = job_runs[i] + 1;
                        replies_due.push_back('{REPLY_FIRE, ST_OK, job_id[i], i[3:0],
                                                job_action[i], job_runs[i], 1'b0});
                        if (job_kind[i] == KIND_ONESHOT) begin
                            job_enabled[i] = 1'b0;
                            job_due[i]     = 64'd0;
                        end else if (job_kind[i] == KIND_INTERVAL) begin
                            step       = ms_to_ticks(job_ms[i]);
                            job_due[i] = job_due[i] + step;
                            if (job_due[i] <= q.now) job_due[i] = q.now + step;
                        end
                    end
                end
                replies_due.push_back(ack(ST_OK, 32'd0, 4'd0));
            end
        endcase
    endfunction

    // present one request and wait for it to be taken
    task automatic send_request(t_request q);
        while (idle_now()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= q.req;
        i_job_kind    <= q.kind;
        i_action_code <= q.action;
        i_interval_ms <= q.ms;
        i_hour        <= q.hour;
        i_minute      <= q.minute;
        i_weekday     <= q.wday;
        i_clock_day   <= q.day;
        i_job_id      <= q.id;
        i_enable_flag <= q.en;
        i_now_tick    <= q.now;
        do @(posedge i_clk); while (o_in_stall);
        serve_request(q);
        if (q.typed) begin
            void'(replies_due.pop_back());
            replies_due.push_back(q.want);
        end
    endtask

    // let every reply come home, then write the tick rate
    task automatic set_rate(logic [15:0] v);
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        rate_hz = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_request random_request();
        t_request    q;
        int          r;
        logic [31:0] known[$];
        int          live[$];
        for (int i = 0; i < NJOBS; i++)
            if (job_used[i]) begin
                known.push_back(job_id[i]);
                live.push_back(i);
            end
        r        = $urandom_range(0, 99);
        q.req    = (r < 40) ? REQ_ADD : (r < 55) ? REQ_REMOVE : (r < 70) ? REQ_ENABLE : REQ_SCAN;
        q.kind   = 2'($urandom_range(0, 3));
        q.action = 2'($urandom_range(0, 3));
        q.ms     = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3000) : $urandom;
        q.hour   = ($urandom_range(0, 9) < 9) ? 5'($urandom_range(0, 23)) :
                                                5'($urandom_range(0, 31));
        q.minute = ($urandom_range(0, 9) < 9) ? 6'($urandom_range(0, 59)) :
                                                6'($urandom_range(0, 63));
        q.wday   = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 6)) :
                                                3'($urandom_range(0, 7));
        q.day    = 5'($urandom_range(0, 31));
        q.id     = (known.size() != 0 && $urandom_range(0, 9) < 8) ?
                   known[$urandom_range(0, known.size() - 1)] : $urandom;
        q.en     = ($urandom_range(0, 9) < 8);
        if (q.req == REQ_SCAN) begin
            cur_now = cur_now + $urandom_range(0, 1500);
            // aim at a stored wall time half of the time
            if (live.size() != 0 && $urandom_range(0, 1)) begin
                r      = live[$urandom_range(0, live.size() - 1)];
                q.hour = job_hour[r];
                q.minute = job_minute[r];
                if ($urandom_range(0, 1)) q.wday = job_wday[r];
            end
        end
        q.now   = ($urandom_range(0, 99) < 3) ? {$urandom, $urandom} : cur_now;
        q.typed = 0;
        q.want  = '0;
        return q;
    endfunction

    // result side: random stall and compare
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= idle_now();
            if (o_out_valid && !i_out_stall) begin
                got = '{o_reply_kind, o_status, o_result_id, o_result_slot,
                        o_result_action, o_result_runs, o_last_item};
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected reply %p", $time, got);
                    n_err++;
                end else begin
                    want = replies_due.pop_front();
                    if (got.reply_kind !== want.reply_kind || got.status !== want.status ||
                        got.id !== want.id || got.slot !== want.slot ||
                        got.action !== want.action || got.runs !== want.runs ||
                        got.last !== want.last) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        n_err++;
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        t_request    plan[$];
        t_request    q;
        logic [63:0] top;
        logic [15:0] rates[4];
        top = '1;
        n_err = 0;
        cycles = 0;
        quiet = 0;
        cur_now = 64'd0;
        rate_hz = DEFAULT_RATE;
        id_counter = 32'd1;
        for (int i = 0; i < NJOBS; i++) begin
            job_used[i] = 1'b0;
            job_enabled[i] = 1'b0;
        end
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_req_type <= REQ_SCAN;
        i_job_kind <= KIND_ONESHOT;
        i_action_code <= '0;
        i_interval_ms <= '0;
        i_hour <= '0;
        i_minute <= '0;
        i_weekday <= '0;
        i_clock_day <= '0;
        i_job_id <= '0;
        i_enable_flag <= 1'b0;
        i_now_tick <= '0;

        // req kind act ms hour min wday day id en now typed want
        plan = '{
            '{REQ_SCAN,   KIND_ONESHOT,  2'd0, 32'd0, 5'd0, 6'd0, 3'd0, 5'd0, 32'd0, 1'b0,
              64'd0, 1, ack(ST_OK, 32'd0, 4'd0)},
            '{REQ_ADD,    KIND_ONESHOT,  2'd0, 32'd0, 5'd0, 6'd0, 3'd0, 5'd0, 32'd0, 1'b1,
              64'd0, 1, ack(ST_OK, 32'd1, 4'd0)},
            '{REQ_ADD,    KIND_INTERVAL, 2'd1, 32'd4000, 5'd0, 6'd0, 3'd0, 5'd0, 32'd0, 1'b1,
              64'd0, 1, ack(ST_OK, 32'd2, 4'd1)},
            '{REQ_ADD,    KIND_DAILY,    2'd2, 32'd0, 5'd23, 6'd59, 3'd0, 5'd0, 32'd0, 1'b1,
              64'd0, 1, ack(ST_OK, 32'd3, 4'd2)},
            '{REQ_ADD,    KIND_WEEKLY,   2'd3, 32'd0, 5'd0, 6'd0, 3'd6, 5'd0, 32'd0, 1'b1,
              64'd0, 1, ack(ST_OK, 32'd4, 4'd3)},
            '{REQ_ADD,    KIND_INTERVAL, 2'd1, '1, 5'd0, 6'd0, 3'd0, 5'd0, 32'd0, 1'b1,
              top - 64'd15, 1, ack(ST_OK, 32'd5, 4'd4)},
            '{REQ_SCAN,   KIND_ONESHOT,  2'd0, 32'd0, 5'd23, 6'd59, 3'd0, 5'd31, 32'd0, 1'b0,
              64'd1, 0, '0},
            '{REQ_SCAN,   KIND_ONESHOT,  2'd0, 32'd0, 5'd23, 6'd59, 3'd0, 5'd31, 32'd0, 1'b0,
              64'd1, 0, '0},
            '{REQ_SCAN,   KIND_ONESHOT,  2'd0, 32'd0, 5'd0, 6'd0, 3'd6, 5'd0, 32'd0, 1'b0,
              64'd5000, 0, '0},
            '{REQ_REMOVE, KIND_ONESHOT,  2'd0, 32'd0, 5'd0, 6'd0, 3'd0, 5'd0, 32'd0, 1'b0,
              64'd0, 1, ack(ST_NOTFOUND, 32'd0, 4'd0)},
            '{REQ_ENABLE, KIND_ONESHOT,  2'd0, 32'd0, 5'd0, 6'd0, 3'd0, 5'd0, '1, 1'b1,
              64'd0, 1, ack(ST_NOTFOUND, '1, 4'd0)},
            '{REQ_ENABLE, KIND_ONESHOT,  2'd0, 32'd0, 5'd0, 6'd0, 3'd0, 5'd0, 32'd1, 1'b1,
              64'd10, 1, ack(ST_OK, 32'd1, 4'd0)},
            '{REQ_ENABLE, KIND_ONESHOT,  2'd0, 32'd0, 5'd0, 6'd0, 3'd0, 5'd0, 32'd3, 1'b0,
              64'd10, 1, ack(ST_OK, 32'd3, 4'd2)},
            '{REQ_SCAN,   KIND_ONESHOT,  2'd0, 32'd0, 5'd23, 6'd59, 3'd6, 5'd31, 32'd0, 1'b0,
              top, 0, '0},
            '{REQ_REMOVE, KIND_ONESHOT,  2'd0, 32'd0, 5'd0, 6'd0, 3'd0, 5'd0, 32'd2, 1'b0,
              64'd0, 1, ack(ST_OK, 32'd2, 4'd1)},
            '{REQ_ADD,    KIND_ONESHOT,  2'd3, 32'd1, 5'd31, 6'd63, 3'd7, 5'd0, 32'd0, 1'b0,
              64'd20, 1, ack(ST_OK, 32'd6, 4'd1)},
            '{REQ_ENABLE, KIND_ONESHOT,  2'd0, 32'd0, 5'd0, 6'd0, 3'd0, 5'd0, 32'd3, 1'b1,
              64'd30, 1, ack(ST_OK, 32'd3, 4'd2)},
            '{REQ_SCAN,   KIND_ONESHOT,  2'd0, 32'd0, 5'd23, 6'd59, 3'd6, 5'd30, 32'd0, 1'b0,
              top, 0, '0},
            '{REQ_ADD,    KIND_WEEKLY,   2'd2, 32'd0, 5'd31, 6'd63, 3'd7, 5'd31, '1, 1'b1,
              64'd40, 1, ack(ST_OK, 32'd7, 4'd5)},
            '{REQ_SCAN,   KIND_ONESHOT,  2'd0, 32'd0, 5'd31, 6'd63, 3'd7, 5'd31, 32'd0, 1'b0,
              top, 0, '0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (plan[k]) send_request(plan[k]);

        // random phases, each under its own tick rate
        rates = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom)};
        for (int p = 0; p < 4; p++) begin
            set_rate(rates[p]);
            for (int n = 0; n < 75; n++) begin
                quiet = (p == 1 && n >= 10 && n < 60);
                q = random_request();
                send_request(q);
            end
        end
        quiet = 0;

        // drain
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_err == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
